[rtl/sorted_byte_table_macros.svh]
// ----------------------------------------------------------------------------
// Sorted byte table assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_BYTE_TABLE_MACROS_SVH
`define SORTED_BYTE_TABLE_MACROS_SVH

// same-cycle implication, off during reset
`define SBT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_byte_table: same-cycle check failed");

// next-cycle implication, off during reset
`define SBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_byte_table: next-cycle check failed");

`endif

[rtl/sbt_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted byte table package
// Transaction types, status codes and control types shared by the block.
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic {
    SBT_IDLE,
    SBT_EXEC
  } sbt_state_t;

  typedef struct packed {
    action_t            action;
    logic signed [7:0]  value;
  } item_in_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   count;
  } result_t;

  typedef struct packed {
    logic               insert_en;
    logic               remove_en;
    logic signed [7:0]  value;
  } cell_ctrl_t;

endpackage

[rtl/sbt_cell.sv]
// ----------------------------------------------------------------------------
// Sorted byte table cell
// Holds one entry; compares it with the operand and shifts toward a neighbor.
// ----------------------------------------------------------------------------
module sbt_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  logic                clk,
  input  sbt_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       count,
  input  logic signed [7:0]   left_val,
  input  logic                left_lt,
  input  logic signed [7:0]   right_val,
  output logic signed [7:0]   val,
  output logic                lt,
  output logic                hit
);

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic signed [7:0] entry;
  logic              valid;

  assign valid = IDX < count;
  assign lt    = valid && ($signed(entry) < $signed(ctrl.value));
  assign hit   = valid && left_lt && ($signed(entry) == $signed(ctrl.value));
  assign val   = entry;

  always_ff @(posedge clk) begin
    if (ctrl.insert_en && !lt) begin
      entry <= left_lt ? ctrl.value : left_val;
    end else if (ctrl.remove_en && !lt) begin
      entry <= right_val;
    end
  end

endmodule

[rtl/sorted_byte_table.sv]
// ----------------------------------------------------------------------------
// Sorted byte table
// Signed byte store kept in ascending order by a row of compare/shift cells.
//
//   channel   handshake         payload
//   command   start / busy      cmd    (action, value)
//   result    done strobe       result (status, count)
//
// The accept cycle latches an item and the execute cycle lets every cell
// compare and shift in parallel; done rises in the cycle after execute.
// busy is high only in the execute cycle; the next start may come while done
// shows. Reset empties the store at once; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_byte_table #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sbt_pkg::item_in_t cmd,
  output logic              done,
  output sbt_pkg::result_t  result
);

  localparam int CW = $clog2(CAPACITY + 1);

  sbt_pkg::sbt_state_t state, state_next;
  sbt_pkg::item_in_t   item;
  sbt_pkg::cell_ctrl_t ctrl;
  sbt_pkg::status_t    status_next;

  logic [CW-1:0]         fill_count, fill_count_next;
  logic [CW+4:0]         count_ext;
  logic                  full, found, exec;
  logic [CAPACITY-1:0]   lt, hit;
  logic signed [7:0]     vals [CAPACITY];

  always_comb begin
    state_next = state;
    unique case (state)
      sbt_pkg::SBT_IDLE: if (start) state_next = sbt_pkg::SBT_EXEC;
      sbt_pkg::SBT_EXEC: state_next = sbt_pkg::SBT_IDLE;
      default:           state_next = sbt_pkg::SBT_IDLE;
    endcase
  end

  always_comb begin
    exec = 1'b0;
    unique case (state)
      sbt_pkg::SBT_IDLE: exec = 1'b0;
      sbt_pkg::SBT_EXEC: exec = 1'b1;
      default:           exec = 1'b0;
    endcase
  end

  assign busy  = exec;
  assign full  = fill_count == CW'(CAPACITY);
  assign found = |hit;

  always_comb begin
    ctrl.value     = item.value;
    ctrl.insert_en = exec && (item.action == sbt_pkg::ACT_INSERT) && !full;
    ctrl.remove_en = exec && (item.action == sbt_pkg::ACT_REMOVE) && found;
  end

  always_comb begin
    fill_count_next = fill_count;
    status_next     = sbt_pkg::STATUS_DONE;
    if (item.action == sbt_pkg::ACT_INSERT) begin
      if (full) begin
        status_next = sbt_pkg::STATUS_FULL;
      end else begin
        fill_count_next = fill_count + CW'(1);
      end
    end else if (found) begin
      fill_count_next = fill_count - CW'(1);
    end else begin
      status_next = sbt_pkg::STATUS_MISSING;
    end
  end

  assign count_ext = (CW + 5)'(fill_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sbt_pkg::SBT_IDLE;
      fill_count <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec;
      if (exec) begin
        fill_count <= fill_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !exec) begin
      item <= cmd;
    end
    if (exec) begin
      result.status <= status_next;
      result.count  <= count_ext[4:0];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [7:0] left_val, right_val;
    logic              left_lt;

    if (i == 0) begin : g_head
      assign left_val = vals[i];
      assign left_lt  = 1'b1;
    end else begin : g_body
      assign left_val = vals[i-1];
      assign left_lt  = lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = vals[i];
    end else begin : g_mid
      assign right_val = vals[i+1];
    end

    sbt_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (fill_count),
      .left_val  (left_val),
      .left_lt   (left_lt),
      .right_val (right_val),
      .val       (vals[i]),
      .lt        (lt[i]),
      .hit       (hit[i])
    );
  end

endmodule

[rtl/sbt_checker.sv]
// ----------------------------------------------------------------------------
// Sorted byte table checker
// Port-level timing checks on transactions, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_byte_table_macros.svh"

module sbt_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input sbt_pkg::result_t result
);

  logic accept;

  assign accept = start && !busy;

  `SBT_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `SBT_ASSERT_NEXT(a_busy_done, clk, rst, busy, !busy && done)
  `SBT_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `SBT_ASSERT_SAME(a_done_after_busy, clk, rst, done, $past(busy))
  `SBT_ASSERT_SAME(a_result_known, clk, rst, done, !$isunknown(result))

endmodule

bind sorted_byte_table sbt_checker u_sbt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
